[rtl/core/u8u16_pkg.sv]
// shared types and constants for the utf-8 to ucs-2 stream decoder
package u8u16_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;

    // utf-8 lead and continuation patterns
    localparam logic [7:0] ASCII_MASK   = 8'b1000_0000;
    localparam logic [7:0] LEAD2_MASK   = 8'b1110_0000;
    localparam logic [7:0] LEAD2_CODE   = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK   = 8'b1111_0000;
    localparam logic [7:0] LEAD3_CODE   = 8'b1110_0000;
    localparam logic [7:0] PAYLOAD_MASK = 8'b0011_1111;

    localparam logic [UNIT_W-1:0] REPLACEMENT_UNIT = 16'hFFFD;

    // continuation bytes still awaited
    typedef enum logic [1:0] {
        EXP_NONE = 2'd0,
        EXP_ONE  = 2'd1,
        EXP_TWO  = 2'd2,
        EXP_RSVD = 2'd3
    } expect_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              bad_sequence;
        logic              end_of_text;
    } result_t;

    // handshake state handed from the input stage to the decoder
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } held_item_t;

endpackage

[rtl/core/u8u16_byte_if.sv]
// channel carrying utf-8 bytes with an end-of-text mark
interface u8u16_byte_if;
    logic                          valid;
    logic                          ready;
    logic [u8u16_pkg::BYTE_W-1:0]  in_byte;
    logic                          in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/core/u8u16_unit_if.sv]
// channel carrying one ucs-2 code unit as two ordered bytes plus flags
interface u8u16_unit_if;
    logic                          valid;
    logic                          ready;
    logic [u8u16_pkg::BYTE_W-1:0]  first_byte;
    logic [u8u16_pkg::BYTE_W-1:0]  second_byte;
    logic                          bad_sequence;
    logic                          end_of_text;

    modport source (output valid, output first_byte, output second_byte,
                    output bad_sequence, output end_of_text, input ready);
    modport sink   (input valid, input first_byte, input second_byte,
                    input bad_sequence, input end_of_text, output ready);
endinterface

[rtl/core/u8u16_in_stage.sv]
// input register stage for incoming utf-8 bytes
module u8u16_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    u8u16_byte_if.sink            text,
    input  logic                  advance,
    output u8u16_pkg::held_item_t item
);

    logic                         valid_reg;
    logic [u8u16_pkg::BYTE_W-1:0] byte_reg;
    logic                         last_reg;

    assign text.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            byte_reg <= text.in_byte;
            last_reg <= text.in_last;
        end
    end

    assign item.valid   = valid_reg;
    assign item.in_byte = byte_reg;
    assign item.in_last = last_reg;

endmodule

[rtl/core/u8u16_decode.sv]
// sequence state and per-byte decode into one code unit
module u8u16_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8u16_pkg::held_item_t item,
    input  logic                  byte_order_big,
    input  logic                  out_free,
    output logic                  advance,
    output logic                  emit,
    output u8u16_pkg::result_t    result
);

    u8u16_pkg::expect_t           exp_reg, exp_next;
    logic [u8u16_pkg::BYTE_W-1:0] lead_reg, lead_next;
    logic [u8u16_pkg::BYTE_W-1:0] mid_reg, mid_next;
    logic                         failed_reg, failed_next;

    logic [u8u16_pkg::UNIT_W-1:0] unit;
    logic                         bad;
    logic [u8u16_pkg::BYTE_W-1:0] b;
    logic                         last;
    logic                         is_lead2;
    logic                         is_lead3;
    logic [u8u16_pkg::BYTE_W-1:0] hi;
    logic [u8u16_pkg::BYTE_W-1:0] lo;

    assign b        = item.in_byte;
    assign last     = item.in_last;
    assign is_lead2 = (b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE;
    assign is_lead3 = (b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE;

    always_comb
    begin
        exp_next    = exp_reg;
        lead_next   = lead_reg;
        mid_next    = mid_reg;
        failed_next = failed_reg;
        unit        = '0;
        bad         = 1'b0;
        emit        = 1'b0;

        if (failed_reg)
        begin
            // drop bytes until end of text
            emit = last;
            bad  = 1'b1;
        end
        else
        begin
            case (exp_reg)
                u8u16_pkg::EXP_TWO:
                begin
                    if (last)
                    begin
                        emit = 1'b1;
                        unit = u8u16_pkg::REPLACEMENT_UNIT;
                    end
                    else
                    begin
                        mid_next = b;
                        exp_next = u8u16_pkg::EXP_ONE;
                    end
                end
                u8u16_pkg::EXP_ONE:
                begin
                    emit = 1'b1;
                    if ((lead_reg & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE)
                    begin
                        unit = {lead_reg[3:0], mid_reg[5:0], b[5:0]};
                    end
                    else
                    begin
                        unit = {5'b0, lead_reg[4:0], b[5:0]};
                    end
                    exp_next  = u8u16_pkg::EXP_NONE;
                    lead_next = '0;
                    mid_next  = '0;
                end
                default:
                begin
                    // idle, including the unused count
                    exp_next = u8u16_pkg::EXP_NONE;
                    if ((b & u8u16_pkg::ASCII_MASK) == 8'h00)
                    begin
                        emit = 1'b1;
                        unit = {8'h00, b};
                    end
                    else if (is_lead2 || is_lead3)
                    begin
                        if (last)
                        begin
                            emit = 1'b1;
                            unit = u8u16_pkg::REPLACEMENT_UNIT;
                        end
                        else
                        begin
                            lead_next = b;
                            mid_next  = '0;
                            exp_next  = is_lead2 ? u8u16_pkg::EXP_ONE : u8u16_pkg::EXP_TWO;
                        end
                    end
                    else
                    begin
                        emit        = 1'b1;
                        bad         = 1'b1;
                        failed_next = !last;
                    end
                end
            endcase
        end

        // end of text returns everything to idle
        if (emit && last)
        begin
            exp_next    = u8u16_pkg::EXP_NONE;
            lead_next   = '0;
            mid_next    = '0;
            failed_next = 1'b0;
        end
    end

    assign advance = item.valid && (!emit || out_free);

    assign hi = bad ? '0 : unit[15:8];
    assign lo = bad ? '0 : unit[7:0];

    assign result.first_byte   = byte_order_big ? hi : lo;
    assign result.second_byte  = byte_order_big ? lo : hi;
    assign result.bad_sequence = bad;
    assign result.end_of_text  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg    <= u8u16_pkg::EXP_NONE;
            lead_reg   <= '0;
            mid_reg    <= '0;
            failed_reg <= 1'b0;
        end
        else if (advance)
        begin
            exp_reg    <= exp_next;
            lead_reg   <= lead_next;
            mid_reg    <= mid_next;
            failed_reg <= failed_next;
        end
    end

endmodule

[rtl/core/u8u16_out_stage.sv]
// result register holding one code unit until its transfer
module u8u16_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  u8u16_pkg::result_t result,
    output logic               out_free,
    u8u16_unit_if.source       units
);

    logic               valid_reg;
    u8u16_pkg::result_t data_reg;

    assign out_free = !valid_reg || units.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (units.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign units.valid        = valid_reg;
    assign units.first_byte   = data_reg.first_byte;
    assign units.second_byte  = data_reg.second_byte;
    assign units.bad_sequence = data_reg.bad_sequence;
    assign units.end_of_text  = data_reg.end_of_text;

endmodule

[rtl/core/utf8_to_ucs2_stream_core.sv]
// top level of the streaming utf-8 to ucs-2 decoder
// text: valid/ready channel of utf-8 bytes, in_last marks the final byte of a text.
// units: valid/ready channel of code units, two bytes in the configured order,
//   bad_sequence flags an unsupported lead or stray continuation byte,
//   end_of_text marks the result caused by the final byte.
// cfg_write_en/cfg_write_data: byte_order_big, 1 sends the high byte first;
//   write it only while no text is in flight.
// one byte is taken per cycle unless a receiver stall holds it back; a byte is held
// in the input register and decoded from there into the result register, which
// drives units until the result transfers.
// lead and middle bytes of a sequence give no result unless they end the text.
// a 4-byte lead or stray continuation yields an error result; later bytes of
// that text are dropped until the final one, which gives a closing error.
// a sequence cut short by end of text gives 0xFFFD.
// when the receiver stalls, the result register holds and the input register
// keeps taking bytes that give no result; otherwise text.ready drops.
// reset clears the sequence state, both stages and sets little-endian order.
module utf8_to_ucs2_stream_core (
    input  logic          clk,
    input  logic          rst_n,
    u8u16_byte_if.sink    text,
    u8u16_unit_if.source  units,
    input  logic          cfg_write_en,
    input  logic          cfg_write_data
);

    logic                  byte_order_big_reg;
    logic                  advance;
    logic                  emit;
    logic                  out_free;
    u8u16_pkg::held_item_t item;
    u8u16_pkg::result_t    result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_order_big_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            byte_order_big_reg <= cfg_write_data;
        end
    end

    u8u16_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .advance (advance),
        .item    (item)
    );

    u8u16_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .byte_order_big (byte_order_big_reg),
        .out_free       (out_free),
        .advance        (advance),
        .emit           (emit),
        .result         (result)
    );

    u8u16_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && emit),
        .result   (result),
        .out_free (out_free),
        .units    (units)
    );

endmodule

[sim/tb_utf8_to_ucs2_stream_core.sv]
// testbench for the utf-8 to ucs-2 stream decoder: directed table, random texts, self-checking
module tb_utf8_to_ucs2_stream_core;

    localparam int PHASE_BYTES = 350;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_ROWS    = 25;

    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic               typed;
        u8u16_pkg::result_t code;
    } text_row_t;

    // typed rows carry a result read straight off the decode rules; others use the predictor
    localparam text_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0}},
        '{8'h7F, 1'b0, 1'b1, '{8'h7F, 8'h00, 1'b0, 1'b0}},
        '{8'h41, 1'b1, 1'b1, '{8'h41, 8'h00, 1'b0, 1'b1}},
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'hA9, 1'b0, 1'b0, '0},
        '{8'hDF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hE2, 1'b0, 1'b0, '0},
        '{8'h82, 1'b0, 1'b0, '0},
        '{8'hAC, 1'b0, 1'b0, '0},
        '{8'hEF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b1, '{8'hFF, 8'hFF, 1'b0, 1'b0}},
        '{8'hC0, 1'b1, 1'b1, '{8'hFD, 8'hFF, 1'b0, 1'b1}},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'hA0, 1'b1, 1'b1, '{8'hFD, 8'hFF, 1'b0, 1'b1}},
        '{8'h80, 1'b0, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b0}},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1}},
        '{8'hF0, 1'b1, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1}},
        '{8'hC3, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b0}},
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'hE0, 1'b1, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1}}
    };

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    u8u16_byte_if text_ch ();
    u8u16_unit_if unit_ch ();

    utf8_to_ucs2_stream_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .text           (text_ch),
        .units          (unit_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // decoder state mirrored by the predictor
    logic                 order_big;
    u8u16_pkg::expect_t   awaiting;
    logic [7:0]           lead_hold;
    logic [7:0]           mid_hold;
    logic                 skipping;

    u8u16_pkg::result_t units_due[$];

    logic               row_typed;
    u8u16_pkg::result_t row_code;

    int idle_pct;
    int stall_pct;
    int hold_asked;
    int hold_taken;
    int hold_left;
    int sent;
    int errors;
    int cycles;

    u8u16_pkg::result_t predicted;
    u8u16_pkg::result_t actual;
    u8u16_pkg::result_t wanted;
    bit                 produced;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic bit decode_utf8(input logic [7:0] b, input logic last,
                                       output u8u16_pkg::result_t r);
        logic [15:0] cu;
        bit          bad;
        bit          emit;
        cu   = 16'h0000;
        bad  = 1'b0;
        emit = 1'b1;
        if (skipping)
        begin
            bad  = 1'b1;
            emit = last;
        end
        else if (awaiting == u8u16_pkg::EXP_TWO)
        begin
            if (last)
                cu = u8u16_pkg::REPLACEMENT_UNIT;
            else
            begin
                mid_hold = b;
                awaiting = u8u16_pkg::EXP_ONE;
                emit     = 1'b0;
            end
        end
        else if (awaiting == u8u16_pkg::EXP_ONE)
        begin
            if ((lead_hold & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE)
                cu = {lead_hold[3:0], mid_hold[5:0], b[5:0]};
            else
                cu = {5'd0, lead_hold[4:0], b[5:0]};
            awaiting  = u8u16_pkg::EXP_NONE;
            lead_hold = 8'h00;
            mid_hold  = 8'h00;
        end
        else if ((b & u8u16_pkg::ASCII_MASK) == 8'h00)
            cu = {8'h00, b};
        else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE
                 || (b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE)
        begin
            if (last)
                cu = u8u16_pkg::REPLACEMENT_UNIT;
            else
            begin
                lead_hold = b;
                mid_hold  = 8'h00;
                awaiting  = ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE)
                            ? u8u16_pkg::EXP_ONE : u8u16_pkg::EXP_TWO;
                emit      = 1'b0;
            end
        end
        else
        begin
            bad      = 1'b1;
            skipping = !last;
        end
        if (bad)
            cu = 16'h0000;
        r.first_byte   = order_big ? cu[15:8] : cu[7:0];
        r.second_byte  = order_big ? cu[7:0] : cu[15:8];
        r.bad_sequence = bad;
        r.end_of_text  = last;
        // end of text always leaves the decoder idle
        if (emit && last)
        begin
            awaiting  = u8u16_pkg::EXP_NONE;
            lead_hold = 8'h00;
            mid_hold  = 8'h00;
            skipping  = 1'b0;
        end
        return emit;
    endfunction

    function automatic logic [7:0] cont_byte();
        // continuation bits are not checked, so now and then send anything
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    // predictor and scoreboard, sampled at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
                order_big = cfg_write_data;
            if (text_ch.valid && text_ch.ready)
            begin
                produced = decode_utf8(text_ch.in_byte, text_ch.in_last, predicted);
                if (row_typed)
                    units_due.push_back(row_code);
                else if (produced)
                    units_due.push_back(predicted);
            end
            if (unit_ch.valid && unit_ch.ready)
            begin
                actual = '{unit_ch.first_byte, unit_ch.second_byte,
                           unit_ch.bad_sequence, unit_ch.end_of_text};
                if (units_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected unit transfer: expected none, got %h %h bad=%b end=%b",
                             $time, actual.first_byte, actual.second_byte,
                             actual.bad_sequence, actual.end_of_text);
                end
                else
                begin
                    wanted = units_due.pop_front();
                    if (actual.first_byte !== wanted.first_byte
                        || actual.second_byte !== wanted.second_byte
                        || actual.bad_sequence !== wanted.bad_sequence
                        || actual.end_of_text !== wanted.end_of_text)
                    begin
                        errors++;
                        $display("%0t unit mismatch: expected %h %h bad=%b end=%b,",
                                 $time, wanted.first_byte, wanted.second_byte,
                                 wanted.bad_sequence, wanted.end_of_text,
                                 " got %h %h bad=%b end=%b",
                                 actual.first_byte, actual.second_byte,
                                 actual.bad_sequence, actual.end_of_text);
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_asked != hold_taken)
        begin
            hold_taken    <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            unit_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            unit_ch.ready <= 1'b0;
        end
        else
            unit_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input u8u16_pkg::result_t code);
        while ($urandom_range(99) < idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.in_byte <= b;
        text_ch.in_last <= last;
        row_typed       <= typed;
        row_code        <= code;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_text(input int chars);
        logic [7:0] seq[$];
        int         kind;
        for (int i = 0; i < chars; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
                seq.push_back(8'($urandom_range(127)));
            else if (kind < 60)
            begin
                seq.push_back(8'hC0 | 8'($urandom_range(31)));
                seq.push_back(cont_byte());
            end
            else if (kind < 88)
            begin
                seq.push_back(8'hE0 | 8'($urandom_range(15)));
                seq.push_back(cont_byte());
                seq.push_back(cont_byte());
            end
            else
                // noise: stray continuations, long leads, anything
                seq.push_back(8'($urandom_range(255)));
        end
        // sometimes the text ends in the middle of a sequence
        if (seq.size() > 1 && $urandom_range(9) == 0)
            void'(seq.pop_back());
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1, 1'b0, '0);
    endtask

    task automatic send_texts(input int count);
        int target;
        target = sent + count;
        while (sent < target)
            send_text($urandom_range(1, 10));
    endtask

    task automatic drain_units();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (units_due.size() != 0)
            @(posedge clk);
        // lead and continuation bytes may still sit in the pipe with no result
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_order(input logic big);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= big;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_write_data  = 1'b0;
        text_ch.valid   = 1'b0;
        text_ch.in_byte = 8'h00;
        text_ch.in_last = 1'b0;
        unit_ch.ready   = 1'b0;
        row_typed       = 1'b0;
        row_code        = '0;
        order_big       = 1'b0;
        awaiting        = u8u16_pkg::EXP_NONE;
        lead_hold       = 8'h00;
        mid_hold        = 8'h00;
        skipping        = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        hold_asked      = 0;
        hold_taken      = 0;
        hold_left       = 0;
        sent            = 0;
        errors          = 0;
        cycles          = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].code);
        drain_units();

        write_order(1'b1);
        send_texts(PHASE_BYTES);
        drain_units();

        write_order(1'b0);
        idle_pct = 73;
        send_texts(PHASE_BYTES);
        drain_units();

        write_order(1'b1);
        idle_pct  = 0;
        stall_pct = 73;
        send_texts(PHASE_BYTES);
        drain_units();

        write_order(1'b0);
        idle_pct  = 14;
        stall_pct = 14;
        send_texts(PHASE_BYTES);
        drain_units();

        // long receiver hold-off while bytes keep coming, then a full pause
        write_order(1'b1);
        idle_pct  = 0;
        stall_pct = 0;
        hold_asked++;
        send_texts(120);
        drain_units();
        send_texts(120);
        hold_asked++;
        send_texts(100);

        stall_pct = 0;
        drain_units();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
